[sv/pltint_pkg.sv]
// Shared types and constants of the piecewise linear table interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pltint_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int VAL_W          = 32;
    localparam int IDX_W          = 5;
    localparam int CFG_W          = 6;
    localparam int QBITS          = 34;
    localparam int DCNT_W         = 6;

    localparam logic [CFG_W-1:0] POINTS_RST = 6'd2;
    localparam logic [QBITS-1:0] QUOT_CLAMP = {1'b1, 33'b0};

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_BELOW  = 2'd1,
        REGION_ABOVE  = 2'd2
    } region_t;

    typedef struct packed {
        logic wr_point;
        logic start;
        logic cnt_clr;
        logic cnt_inc;
        logic first_step;
        logic scan_step;
        logic res_above;
        logic res_below;
        logic res_r0;
        logic res_zero;
        logic res_sum;
        logic diff;
        logic mul;
        logic neg;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ge_last;
        logic le_first;
        logic scan_done;
        logic found;
        logic seg_flat;
        logic div_ovf;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

[sv/pltint_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the breakpoint domain and range stores.
`timescale 1ns / 1ps
`default_nettype none

module pltint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/pltint_ctrl.sv]
// Sequencing state machine of the interpolator: handshakes, search, divide steps.
// Depends on pltint_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module pltint_ctrl
    import pltint_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    in_action,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t st
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_RDLAST   = 12'b0000_0000_0010,
        ST_CHKLAST  = 12'b0000_0000_0100,
        ST_CHKFIRST = 12'b0000_0000_1000,
        ST_SCAN     = 12'b0000_0001_0000,
        ST_SEG      = 12'b0000_0010_0000,
        ST_MUL      = 12'b0000_0100_0000,
        ST_NEG      = 12'b0000_1000_0000,
        ST_DINIT    = 12'b0001_0000_0000,
        ST_DIV      = 12'b0010_0000_0000,
        ST_SAT      = 12'b0100_0000_0000,
        ST_OUT      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ACT_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RDLAST;
                    end
                    else
                    begin
                        cmd.wr_point = 1'b1;
                    end
                end
            end
            ST_RDLAST:
            begin
                cmd.cnt_clr = 1'b1;
                state_next  = ST_CHKLAST;
            end
            ST_CHKLAST:
            begin
                if (st.ge_last)
                begin
                    cmd.res_above = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_CHKFIRST;
                end
            end
            ST_CHKFIRST:
            begin
                if (st.le_first)
                begin
                    cmd.res_below = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.first_step = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                begin
                    state_next = ST_SEG;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_SEG:
            begin
                if (!st.found)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (st.seg_flat)
                begin
                    cmd.res_r0 = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.diff   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_NEG;
            end
            ST_NEG:
            begin
                cmd.neg    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = st.div_ovf ? ST_SAT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                cmd.res_sum = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[sv/pltint_dpath.sv]
// Datapath: breakpoint stores, segment search, multiply, restoring divide, saturation.
// Depends on pltint_pkg and pltint_ram; sequenced by pltint_ctrl via cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pltint_dpath
    import pltint_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output status_t                      st,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_W-1:0]        cfg_wr_data,
    input  wire logic [IDX_W-1:0]        point_index,
    input  wire logic signed [VAL_W-1:0] point_domain,
    input  wire logic signed [VAL_W-1:0] point_range,
    input  wire logic signed [VAL_W-1:0] query_position,
    output logic signed [VAL_W-1:0]      value,
    output logic [1:0]                   region
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;

    logic [CFG_W-1:0]        points_reg;
    logic [NW-1:0]           n_reg;
    logic [NW-1:0]           cnt_reg;
    logic                    found_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;

    logic signed [VAL_W-1:0] q_reg;
    logic signed [VAL_W-1:0] prev_d_reg, prev_r_reg;
    logic signed [VAL_W-1:0] seg_d0_reg, seg_d1_reg, seg_r0_reg, seg_r1_reg;
    logic [31:0]             a_reg, b_reg, dv_reg;
    logic                    sign_reg;
    logic [63:0]             prod_reg, mag_reg;
    logic                    neg_reg;
    logic [31:0]             rem_reg;
    logic [QBITS-1:0]        sh_reg;
    logic                    ovf_reg;
    logic signed [VAL_W-1:0] res_value_reg, out_value_reg;
    region_t                 res_region_reg, out_region_reg;

    logic [NW-1:0]           n_eff;
    logic                    idx_ok;
    logic [IW-1:0]           idx_ext;
    logic [VAL_W-1:0]        ram_d_rdata, ram_r_rdata;
    logic signed [VAL_W-1:0] rd_d, rd_r;

    logic [32:0]             dr, dr_neg, qd, dd;
    logic [63:0]             prod_c, prod_neg;
    logic                    neg_c;
    logic [32:0]             div_t, div_sub;
    logic                    div_ge;
    logic [31:0]             rem_next;
    logic [QBITS-1:0]        sh_next;
    logic [QBITS-1:0]        quot_c;
    logic [QBITS+1:0]        quot_x, sq, sum;
    logic signed [VAL_W-1:0] sat_value;

    // Table stores
    assign idx_ext = IW'(point_index);
    assign idx_ok  = ({{(32-IDX_W){1'b0}}, point_index} < 32'(MAX_POINTS));

    pltint_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_dom_ram (
        .clk   (clk),
        .we    (cmd.wr_point && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (point_domain),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_d_rdata)
    );

    pltint_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_rng_ram (
        .clk   (clk),
        .we    (cmd.wr_point && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (point_range),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_r_rdata)
    );

    assign rd_d = $signed(ram_d_rdata);
    assign rd_r = $signed(ram_r_rdata);

    always_comb
    begin
        if ({{(32-CFG_W){1'b0}}, points_reg} < 32'd2)
        begin
            n_eff = NW'(2);
        end
        else if ({{(32-CFG_W){1'b0}}, points_reg} > 32'(MAX_POINTS))
        begin
            n_eff = NW'(MAX_POINTS);
        end
        else
        begin
            n_eff = NW'(points_reg);
        end
    end

    // Segment arithmetic
    assign dr     = {seg_r1_reg[VAL_W-1], seg_r1_reg} - {seg_r0_reg[VAL_W-1], seg_r0_reg};
    assign dr_neg = -dr;
    assign qd     = {q_reg[VAL_W-1], q_reg} - {seg_d0_reg[VAL_W-1], seg_d0_reg};
    assign dd     = {seg_d1_reg[VAL_W-1], seg_d1_reg} - {seg_d0_reg[VAL_W-1], seg_d0_reg};

    assign prod_c   = a_reg * b_reg;
    assign prod_neg = -prod_reg;
    assign neg_c    = sign_reg ? prod_neg[63] : prod_reg[63];

    assign div_t    = {rem_reg, sh_reg[QBITS-1]};
    assign div_sub  = div_t - {1'b0, dv_reg};
    assign div_ge   = (div_t >= {1'b0, dv_reg});
    assign rem_next = div_ge ? div_sub[31:0] : div_t[31:0];
    assign sh_next  = {sh_reg[QBITS-2:0], div_ge};

    assign quot_c = (ovf_reg || (sh_reg > QUOT_CLAMP)) ? QUOT_CLAMP : sh_reg;
    assign quot_x = {2'b00, quot_c};
    assign sq     = neg_reg ? -quot_x : quot_x;
    assign sum    = {{(QBITS+2-VAL_W){seg_r0_reg[VAL_W-1]}}, seg_r0_reg} + sq;

    always_comb
    begin
        if (sum[QBITS+1:VAL_W-1] == '0 || sum[QBITS+1:VAL_W-1] == '1)
        begin
            sat_value = $signed(sum[VAL_W-1:0]);
        end
        else if (sum[QBITS+1])
        begin
            sat_value = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // Status
    assign st.ge_last   = (q_reg >= rd_d);
    assign st.le_first  = (q_reg <= rd_d);
    assign st.scan_done = (cnt_reg == n_reg);
    assign st.found     = found_reg;
    assign st.seg_flat  = (seg_d1_reg <= seg_d0_reg);
    assign st.div_ovf   = ({2'b00, mag_reg[63:QBITS]} >= dv_reg);
    assign st.div_done  = (div_cnt_reg == DCNT_W'(QBITS - 1));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg  <= POINTS_RST;
            n_reg       <= NW'(2);
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                points_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                n_reg   <= n_eff;
                cnt_reg <= n_eff - NW'(1);
            end
            else if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            if (cmd.start || cmd.first_step)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step && (prev_d_reg <= q_reg) && (q_reg <= rd_d))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg <= query_position;
        end
        if (cmd.first_step || cmd.scan_step)
        begin
            prev_d_reg <= rd_d;
            prev_r_reg <= rd_r;
        end
        if (cmd.scan_step && (prev_d_reg <= q_reg) && (q_reg <= rd_d))
        begin
            seg_d0_reg <= prev_d_reg;
            seg_r0_reg <= prev_r_reg;
            seg_d1_reg <= rd_d;
            seg_r1_reg <= rd_r;
        end
        if (cmd.diff)
        begin
            sign_reg <= dr[32];
            a_reg    <= dr[32] ? dr_neg[31:0] : dr[31:0];
            b_reg    <= qd[31:0];
            dv_reg   <= dd[31:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.neg)
        begin
            neg_reg <= neg_c;
            mag_reg <= (sign_reg ^ neg_c) ? prod_neg : prod_reg;
        end
        if (cmd.div_init)
        begin
            ovf_reg <= st.div_ovf;
            rem_reg <= {2'b00, mag_reg[63:QBITS]};
            sh_reg  <= mag_reg[QBITS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
        if (cmd.res_above || cmd.res_below)
        begin
            res_value_reg  <= rd_r;
            res_region_reg <= cmd.res_above ? REGION_ABOVE : REGION_BELOW;
        end
        else if (cmd.res_r0)
        begin
            res_value_reg  <= seg_r0_reg;
            res_region_reg <= REGION_INSIDE;
        end
        else if (cmd.res_zero)
        begin
            res_value_reg  <= '0;
            res_region_reg <= REGION_INSIDE;
        end
        else if (cmd.res_sum)
        begin
            res_value_reg  <= sat_value;
            res_region_reg <= REGION_INSIDE;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_region_reg <= res_region_reg;
        end
    end

    assign value  = out_value_reg;
    assign region = out_region_reg;

`ifndef ASSERT_OFF
    a_cnt_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= n_reg)
        else $error("search counter beyond points in use");

    a_seg_holds_query: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (seg_d0_reg <= q_reg) && (q_reg <= seg_d1_reg))
        else $error("latched segment does not bracket the query");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < dv_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

[sv/piecewise_linear_table_interpolator_core.sv]
// Piecewise linear table interpolator core.
//
// s_axis: one word per item. tuser = action (0 write breakpoint, 1 evaluate).
//   Write words load domain/range at point_index; the core stays ready for the next word.
// m_axis: one word per evaluate: tdata = value, tuser = region.
// cfg_wr_en/cfg_wr_data write points_in_use (clamped to 2..MAX_POINTS on use).
// Evaluate, from acceptance to next possible acceptance (n = points in use):
//   at or above last domain it ends at the last-entry check, at or below first
//   at the first-entry check, a flat or missing segment after a sequential read
//   of the domain/range RAMs over all n entries; interpolation adds a multiply
//   and the one-bit-per-cycle 34-step restoring divider (skipped if the quotient clamps).
// One item is in work at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so the next word is taken while
// m_axis waits; a stalled receiver only holds back the next evaluate result.
// Reset (rst_n, asynchronous) clears control state and sets points_in_use
// to 2; the breakpoint stores are not cleared and must be written first.
// Depends on pltint_pkg, pltint_ctrl, pltint_dpath, pltint_ram.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interpolator_core
    import pltint_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [4:0] point_index, [36:5] point_domain, [68:37] point_range,
    // [100:69] query_position, [103:101] zero
    input  wire logic [103:0]       s_axis_tdata,
    // [0] action
    input  wire logic [0:0]         s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [31:0] value
    output logic [31:0]             m_axis_tdata,
    // [1:0] region
    output logic [1:0]              m_axis_tuser,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data
);

    cmd_t    cmd;
    status_t st;

    pltint_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .st        (st)
    );

    pltint_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .point_index    (s_axis_tdata[4:0]),
        .point_domain   ($signed(s_axis_tdata[36:5])),
        .point_range    ($signed(s_axis_tdata[68:37])),
        .query_position ($signed(s_axis_tdata[100:69])),
        .value          (m_axis_tdata),
        .region         (m_axis_tuser)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for piecewise_linear_table_interpolator_core.
// Loads breakpoint tables, evaluates queries and checks every result word
// against an in-bench interpolation predictor. Depends on pltint_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import pltint_pkg::*;

    localparam int          MAX_PTS   = 32;
    localparam int          SETTLE    = 100;
    localparam int          MIX_ITEMS = 180;
    localparam longint      CYC_LIMIT = 1000000;
    localparam longint      I32_MAX   = 64'sd2147483647;
    localparam longint      I32_MIN   = -64'sd2147483648;
    localparam logic [31:0] V_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] V_MIN     = 32'h8000_0000;

    typedef struct {
        logic [31:0] value;
        region_t     region;
    } lookup_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [103:0]       s_axis_tdata;   // index, domain, range, query, zero pad
    logic [0:0]         s_axis_tuser;   // action
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;   // value
    logic [1:0]         m_axis_tuser;   // region
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;

    longint             dom_tab [MAX_PTS];
    longint             rng_tab [MAX_PTS];
    int                 pts_cfg = 2;
    lookup_t            pending_lookups [$];
    lookup_t            want;
    int                 mismatches = 0;
    longint             cycles = 0;
    bit                 calm = 0;

    piecewise_linear_table_interpolator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int active_points();
        int n;
        n = pts_cfg;
        if (n < 2)
            n = 2;
        if (n > MAX_PTS)
            n = MAX_PTS;
        return n;
    endfunction

    function automatic logic [31:0] blend_segment(input longint d0, input longint r0,
                                                  input longint d1, input longint r1,
                                                  input longint q);
        logic [63:0] prod;
        logic [63:0] mag;
        logic [63:0] divisor;
        logic [63:0] quot;
        longint      sq;
        longint      sum;
        if (d1 <= d0)
            return 32'(r0);
        prod    = (r1 - r0) * (q - d0);
        mag     = prod[63] ? (64'd0 - prod) : prod;
        divisor = d1 - d0;
        quot    = mag / divisor;
        if (quot > 64'(QUOT_CLAMP))
            quot = 64'(QUOT_CLAMP);
        sq  = prod[63] ? -longint'(quot) : longint'(quot);
        sum = r0 + sq;
        if (sum > I32_MAX)
            sum = I32_MAX;
        if (sum < I32_MIN)
            sum = I32_MIN;
        return 32'(sum);
    endfunction

    function automatic lookup_t interpolate_point(input logic [31:0] q_bits);
        int      n;
        longint  q;
        longint  d0;
        longint  d1;
        longint  r0;
        longint  r1;
        bit      found;
        lookup_t res;
        n     = active_points();
        q     = longint'($signed(q_bits));
        found = 1'b0;
        d0 = 0; d1 = 0; r0 = 0; r1 = 0;
        if (q >= dom_tab[n-1]) begin
            res.value  = 32'(rng_tab[n-1]);
            res.region = REGION_ABOVE;
        end
        else if (q <= dom_tab[0]) begin
            res.value  = 32'(rng_tab[0]);
            res.region = REGION_BELOW;
        end
        else begin
            for (int i = 0; i + 1 < n; i++) begin
                if (q >= dom_tab[i] && q <= dom_tab[i+1]) begin
                    d0 = dom_tab[i];
                    d1 = dom_tab[i+1];
                    r0 = rng_tab[i];
                    r1 = rng_tab[i+1];
                    found = 1'b1;
                end
            end
            res.value  = found ? blend_segment(d0, r0, d1, r1, q) : 32'd0;
            res.region = REGION_INSIDE;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // entered and left at a falling edge
    task automatic push_word(input logic act, input logic [4:0] idx,
                             input logic [31:0] dom, input logic [31:0] rng,
                             input logic [31:0] q);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, q, rng, dom, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == ACT_WRITE) begin
            dom_tab[idx] = longint'($signed(dom));
            rng_tab[idx] = longint'($signed(rng));
        end
        else begin
            pending_lookups.push_back(interpolate_point(q));
        end
        @(negedge clk);
    endtask

    task automatic send_eval(input logic [31:0] q);
        push_word(ACT_EVAL, 5'($urandom), $urandom, $urandom, q);
    endtask

    task automatic set_points(input logic [CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pts_cfg = v;
    endtask

    function automatic logic [31:0] pick_query();
        int          n;
        int          j;
        longint      lo;
        longint      hi;
        longint      v;
        logic [63:0] r;
        n  = active_points();
        lo = dom_tab[0];
        hi = dom_tab[n-1];
        j  = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: v = dom_tab[j];
            3:       v = dom_tab[j] + 1;
            4:       v = dom_tab[j] - 1;
            5, 6, 7:
            begin
                if (hi > lo) begin
                    r = {$urandom, $urandom};
                    v = lo + longint'(r % 64'(hi - lo + 1));
                end
                else begin
                    v = lo;
                end
            end
            default: v = longint'($signed($urandom));
        endcase
        return 32'(v);
    endfunction

    // strictly increasing domains, written in shuffled order
    task automatic load_table(input int mode);
        longint      d;
        int          smax;
        int          j;
        int          t;
        int          perm [MAX_PTS];
        longint      dnew [MAX_PTS];
        logic [31:0] rnew [MAX_PTS];
        case (mode)
            0:
            begin
                d = -longint'($urandom_range(0, 5000));
                smax = 300;
            end
            1:
            begin
                d = -longint'($urandom_range(0, 1 << 20));
                smax = 1 << 16;
            end
            default:
            begin
                d = I32_MIN + longint'($urandom_range(0, 1 << 20));
                smax = 1 << 27;
            end
        endcase
        for (int i = 0; i < MAX_PTS; i++) begin
            dnew[i] = d;
            rnew[i] = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 32'd1000;
            d = d + longint'($urandom_range(1, smax));
            if (d > I32_MAX)
                d = I32_MAX;
            perm[i] = i;
        end
        for (int i = MAX_PTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < MAX_PTS; i++)
            push_word(ACT_WRITE, 5'(perm[i]), 32'(dnew[perm[i]]), rnew[perm[i]], $urandom);
    endtask

    task automatic mixed_items(input int count);
        int sel;
        int j;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 19);
            j   = $urandom_range(0, MAX_PTS - 1);
            if (sel < 15)
                send_eval(pick_query());
            else if (sel < 18)
                push_word(ACT_WRITE, 5'(j), 32'(dom_tab[j]), $urandom, $urandom);
            else
                push_word(ACT_WRITE, 5'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_two_point_extremes();
        push_word(ACT_WRITE, 5'd0, V_MIN, V_MAX, V_MAX);
        push_word(ACT_WRITE, 5'd1, V_MAX, V_MIN, V_MIN);
        send_eval(V_MIN);
        send_eval(V_MAX);
        send_eval(32'd0);
        send_eval(V_MAX - 32'd1);   // product wraps, saturates high
        send_eval(V_MIN + 32'd1);
        push_word(ACT_WRITE, 5'd0, V_MIN, V_MIN, 32'd0);
        push_word(ACT_WRITE, 5'd1, V_MAX, V_MAX, 32'd0);
        send_eval(V_MAX - 32'd1);   // saturates low
        send_eval(32'd1);
    endtask

    task automatic test_clamp_order();
        // last domain equals first: the above-last clamp wins
        push_word(ACT_WRITE, 5'd1, V_MIN, 32'd5, 32'hFFFF_FFFF);
        send_eval(V_MIN);
        send_eval(32'd0);
    endtask

    task automatic test_register_clamp();
        set_points(6'd0);
        push_word(ACT_WRITE, 5'd1, V_MAX, 32'd7, 32'd0);
        send_eval(32'd0);
        set_points(6'd1);
        send_eval(32'hFFFF_FFFB);
    endtask

    task automatic test_full_table();
        load_table(2);
        set_points(6'd63);
        send_eval(32'(dom_tab[0]));
        send_eval(32'(dom_tab[MAX_PTS-1]));
        send_eval(32'(dom_tab[0] + 1));
        send_eval(32'(dom_tab[MAX_PTS-1] - 1));
        mixed_items(20);
    endtask

    task automatic test_random_tables();
        logic [CFG_W-1:0] setting;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       setting = 6'd32;
                1:       setting = 6'd2;
                2:       setting = 6'd33;
                3:       setting = 6'd0;
                4:       setting = 6'd1;
                5:       setting = 6'd17;
                6:       setting = 6'($urandom_range(3, 31));
                7:       setting = 6'($urandom_range(0, 63));
                default: setting = 6'd32;
            endcase
            if (p == 8)
                calm = 1'b1;
            set_points(setting);
            if (p == 0 || $urandom_range(0, 2) != 0)
                load_table($urandom_range(0, 2));
            mixed_items(MIX_ITEMS);
        end
    endtask

    // receiver back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                flag_error($sformatf("unexpected word value %h region %0d",
                                     m_axis_tdata, m_axis_tuser));
            end
            else begin
                want = pending_lookups.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.region)
                    flag_error($sformatf("value exp %h got %h, region exp %0d got %0d",
                                         want.value, m_axis_tdata, want.region,
                                         m_axis_tuser));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_two_point_extremes();
        test_clamp_order();
        test_register_clamp();
        test_full_table();
        test_random_tables();

        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
